### rtl/lla_pkg.sv
// Package for the life-like automaton engine.
// Holds grid sizes, codes, shared structs and the rule lookup; no dependencies.

package lla_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MASK_W = 9;
	localparam int SIZE_W = 7;
	localparam int CNT_W = 4;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [MASK_W-1:0] BIRTH_RESET = MASK_W'(8);
	localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);
	localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_GEN    = 2'd2,
		FUNC_UPDATE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_BIRTH   = 2'd0,
		REG_SURVIVE = 2'd1,
		REG_ROWS    = 2'd2,
		REG_COLS    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return {row, col};
	endfunction

	function automatic logic next_value(input logic alive, input logic [CNT_W-1:0] cnt,
		input cfg_t cfg);
		logic [MASK_W-1:0] mask;
		mask = alive ? cfg.survive : cfg.birth;
		return (cnt < CNT_W'(MASK_W)) ? mask[cnt] : 1'b0;
	endfunction

endpackage

### rtl/lla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module lla_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lla_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on lla_pkg; delivers the rule masks and the clamped grid size.

module lla_cfg import lla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [MASK_W-1:0] birth_q;
	logic [MASK_W-1:0] survive_q;
	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	reg_idx_t          idx;

	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q <= BIRTH_RESET;
			survive_q <= SURVIVE_RESET;
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_BIRTH:   birth_q <= pwdata[MASK_W-1:0];
				REG_SURVIVE: survive_q <= pwdata[MASK_W-1:0];
				REG_ROWS:    rows_q <= pwdata[SIZE_W-1:0];
				REG_COLS:    cols_q <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BIRTH:   prdata = PDATA_W'(birth_q);
			REG_SURVIVE: prdata = PDATA_W'(survive_q);
			REG_ROWS:    prdata = PDATA_W'(rows_q);
			REG_COLS:    prdata = PDATA_W'(cols_q);
		endcase
	end

	always_comb begin
		cfg.birth = birth_q;
		cfg.survive = survive_q;
		priority if (rows_q == '0) begin
			cfg.rows = SIZE_W'(1);
		end else if (rows_q > SIZE_W'(MAX_ROWS)) begin
			cfg.rows = SIZE_W'(MAX_ROWS);
		end else begin
			cfg.rows = rows_q;
		end
		priority if (cols_q == '0) begin
			cfg.cols = SIZE_W'(1);
		end else if (cols_q > SIZE_W'(MAX_COLS)) begin
			cfg.cols = SIZE_W'(MAX_COLS);
		end else begin
			cfg.cols = cols_q;
		end
	end

endmodule

### rtl/lla_seq.sv
// Sequencer: item handling, neighbor scan over the grid memory, generation
// sweep, copy-back pass and the output register. Depends on lla_pkg.

module lla_seq import lla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [ROW_W-1:0] cell_row,
	input  logic [COL_W-1:0] cell_col,
	input  logic             write_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             cell_value,
	output logic [CNT_W-1:0] neighbor_count,
	output mem_req_t         cell_req,
	input  logic             cell_rdata,
	output mem_req_t         next_req,
	input  logic             next_rdata
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_RDREQ  = 8'b0000_0010,
		S_RDWAIT = 8'b0000_0100,
		S_NBR    = 8'b0000_1000,
		S_EVAL   = 8'b0001_0000,
		S_COPY   = 8'b0010_0000,
		S_CDRAIN = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic              wv_q;
	logic              inside_q;
	logic [ROW_W-1:0]  gr_q;
	logic [COL_W-1:0]  gc_q;
	logic [1:0]        dr_q;
	logic [1:0]        dc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              alive_q;
	logic              res_val_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              pend_s1;
	logic              self_s1;
	logic              cpv_s1;
	logic [ADDR_W-1:0] cpaddr_s1;
	logic              out_valid_q;
	logic              cell_value_q;
	logic [CNT_W-1:0]  neighbor_count_q;

	logic              in_fire;
	logic              out_free;
	logic              inside_in;
	logic              last_row;
	logic              last_col;
	logic              last_cell;
	logic              last_nbr;
	logic [SIZE_W-1:0] rt;
	logic [SIZE_W-1:0] ct;
	logic [SIZE_W-1:0] rn;
	logic [SIZE_W-1:0] cn;
	logic              nb_ok;
	logic [CNT_W-1:0]  cnt_sum;
	logic              alive_now;
	logic              new_val;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign inside_in = ({1'b0, cell_row} < cfg.rows) && ({1'b0, cell_col} < cfg.cols);

	assign last_row = ({1'b0, gr_q} == (cfg.rows - SIZE_W'(1)));
	assign last_col = ({1'b0, gc_q} == (cfg.cols - SIZE_W'(1)));
	assign last_cell = last_row && last_col;
	assign last_nbr = (dr_q == 2'd2) && (dc_q == 2'd2);

	// Neighbor coordinates are kept offset by one so that row -1 shows as zero.
	assign rt = {1'b0, gr_q} + SIZE_W'(dr_q);
	assign ct = {1'b0, gc_q} + SIZE_W'(dc_q);
	assign rn = rt - SIZE_W'(1);
	assign cn = ct - SIZE_W'(1);
	assign nb_ok = (rt != '0) && (ct != '0) && (rn < cfg.rows) && (cn < cfg.cols);

	assign cnt_sum = cnt_q + CNT_W'(pend_s1 && !self_s1 && cell_rdata);
	assign alive_now = alive_q || (pend_s1 && self_s1 && cell_rdata);
	assign new_val = next_value(alive_now, cnt_sum, cfg);

	always_comb begin
		cell_req = '0;
		next_req = '0;
		cell_req.re = ((state_q == S_NBR) && nb_ok) || (state_q == S_RDREQ);
		cell_req.raddr = (state_q == S_NBR) ? cell_addr(rn[ROW_W-1:0], cn[COL_W-1:0])
			: cell_addr(gr_q, gc_q);
		priority if (cpv_s1) begin
			cell_req.we = 1'b1;
			cell_req.waddr = cpaddr_s1;
			cell_req.wdata = next_rdata;
		end else if ((state_q == S_EVAL) && (func_q == FUNC_UPDATE)) begin
			cell_req.we = 1'b1;
			cell_req.waddr = cell_addr(gr_q, gc_q);
			cell_req.wdata = new_val;
		end else if ((state_q == S_FIN) && (func_q == FUNC_WRITE) && inside_q && out_free) begin
			cell_req.we = 1'b1;
			cell_req.waddr = cell_addr(gr_q, gc_q);
			cell_req.wdata = wv_q;
		end else begin
			cell_req.we = 1'b0;
		end
		next_req.we = (state_q == S_EVAL) && (func_q == FUNC_GEN);
		next_req.waddr = cell_addr(gr_q, gc_q);
		next_req.wdata = new_val;
		next_req.re = (state_q == S_COPY);
		next_req.raddr = cell_addr(gr_q, gc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			cpv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_NBR) && nb_ok;
			cpv_s1 <= (state_q == S_COPY);
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (func_t'(func))
							FUNC_WRITE:  state_q <= S_FIN;
							FUNC_READ:   state_q <= inside_in ? S_RDREQ : S_FIN;
							FUNC_GEN:    state_q <= S_NBR;
							FUNC_UPDATE: state_q <= inside_in ? S_NBR : S_FIN;
						endcase
					end
				end
				S_RDREQ:  state_q <= S_RDWAIT;
				S_RDWAIT: state_q <= S_FIN;
				S_NBR: begin
					if (last_nbr) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (func_q == FUNC_GEN) begin
						state_q <= last_cell ? S_COPY : S_NBR;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_COPY: begin
					if (last_cell) begin
						state_q <= S_CDRAIN;
					end
				end
				S_CDRAIN: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					func_q <= func_t'(func);
					wv_q <= write_value;
					inside_q <= inside_in;
					res_val_q <= 1'b0;
					res_cnt_q <= '0;
					cnt_q <= '0;
					alive_q <= 1'b0;
					dr_q <= '0;
					dc_q <= '0;
					if (func_t'(func) == FUNC_GEN) begin
						gr_q <= '0;
						gc_q <= '0;
					end else begin
						gr_q <= cell_row;
						gc_q <= cell_col;
					end
				end
			end
			S_RDREQ: begin
			end
			S_RDWAIT: begin
				res_val_q <= cell_rdata;
			end
			S_NBR: begin
				cnt_q <= cnt_sum;
				alive_q <= alive_now;
				self_s1 <= (dr_q == 2'd1) && (dc_q == 2'd1);
				if (dc_q == 2'd2) begin
					dc_q <= '0;
					dr_q <= dr_q + 2'd1;
				end else begin
					dc_q <= dc_q + 2'd1;
				end
			end
			S_EVAL: begin
				if (func_q == FUNC_GEN) begin
					cnt_q <= '0;
					alive_q <= 1'b0;
					dr_q <= '0;
					dc_q <= '0;
					if (last_col) begin
						gc_q <= '0;
						gr_q <= last_row ? '0 : gr_q + ROW_W'(1);
					end else begin
						gc_q <= gc_q + COL_W'(1);
					end
				end else begin
					res_val_q <= new_val;
					res_cnt_q <= cnt_sum;
				end
			end
			S_COPY: begin
				cpaddr_s1 <= cell_addr(gr_q, gc_q);
				if (last_col) begin
					gc_q <= '0;
					gr_q <= gr_q + ROW_W'(1);
				end else begin
					gc_q <= gc_q + COL_W'(1);
				end
			end
			S_CDRAIN: begin
			end
			S_FIN: begin
				if (out_free) begin
					cell_value_q <= res_val_q;
					neighbor_count_q <= res_cnt_q;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign cell_value = cell_value_q;
	assign neighbor_count = neighbor_count_q;

endmodule

### rtl/life_like_automaton_engine.sv
// Life-like automaton engine: one-bit cell grid with write, read, in-place update
// and full-generation items. The grid memory serves one read per cycle, so an update
// steps through the nine cells of its neighborhood, and a full generation does so for
// every cell, then writes the result back from the scratch grid in a copy-back pass.
// A new item is taken in the cycle after its result is loaded into the output register.
// Reset clears control state and the registers to their defaults; the grids stay undefined.

module life_like_automaton_engine import lla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [ROW_W-1:0]   cell_row,
	input  logic [COL_W-1:0]   cell_col,
	input  logic               write_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               cell_value,
	output logic [CNT_W-1:0]   neighbor_count
);

	cfg_t     cfg;
	mem_req_t cell_req;
	mem_req_t next_req;
	logic     cell_rdata;
	logic     next_rdata;

	assign pready = 1'b1;

	lla_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cell_grid (
		.clk   (clk),
		.we    (cell_req.we),
		.waddr (cell_req.waddr),
		.wdata (cell_req.wdata),
		.re    (cell_req.re),
		.raddr (cell_req.raddr),
		.rdata (cell_rdata)
	);

	lla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_next_grid (
		.clk   (clk),
		.we    (next_req.we),
		.waddr (next_req.waddr),
		.wdata (next_req.wdata),
		.re    (next_req.re),
		.raddr (next_req.raddr),
		.rdata (next_rdata)
	);

	lla_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.cell_row       (cell_row),
		.cell_col       (cell_col),
		.write_value    (write_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cell_value     (cell_value),
		.neighbor_count (neighbor_count),
		.cell_req       (cell_req),
		.cell_rdata     (cell_rdata),
		.next_req       (next_req),
		.next_rdata     (next_rdata)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while a previous item is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (neighbor_count <= CNT_W'(8)))
		else $error("neighbor count above eight");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(cell_req.we && cell_req.re))
		else $error("cell grid read and written in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(next_req.we && next_req.re))
		else $error("scratch grid read and written in the same cycle");
`endif

endmodule

### sim/life_like_automaton_engine_checker.sv
// Scoreboard for the life-like automaton engine: keeps its own copy of the grid and
// the rule registers, predicts every result and compares it with what the block returns.
// Depends on lla_pkg for widths and codes.
`timescale 1ns / 1ps

module life_like_automaton_engine_checker import lla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         func,
	input  logic [ROW_W-1:0]   cell_row,
	input  logic [COL_W-1:0]   cell_col,
	input  logic               write_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               cell_value,
	input  logic [CNT_W-1:0]   neighbor_count,
	output int                 fail_count,
	output int                 pending,
	output int                 checked_count
);

	typedef struct packed {
		logic             alive;
		logic [CNT_W-1:0] live_nbrs;
	} cell_result_t;

	cell_result_t      result_q[$];
	bit                grid_q [0:DEPTH-1];
	bit                scratch_q [0:DEPTH-1];
	logic [MASK_W-1:0] birth_r;
	logic [MASK_W-1:0] survive_r;
	logic [SIZE_W-1:0] rows_r;
	logic [SIZE_W-1:0] cols_r;

	initial begin
		fail_count = 0;
		pending = 0;
		checked_count = 0;
	end

	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int max_v);
		if (v == 0)
			return 1;
		if (v > max_v)
			return max_v;
		return v;
	endfunction

	function automatic int live_around(input int r, input int c, input int nr, input int nc);
		int total;
		total = 0;
		for (int i = r - 1; i <= r + 1; i++)
			for (int j = c - 1; j <= c + 1; j++)
				if (i >= 0 && i < nr && j >= 0 && j < nc && !(i == r && j == c))
					total += grid_q[i * MAX_COLS + j];
		return total;
	endfunction

	function automatic logic rule_out(input logic alive, input int n);
		logic [MASK_W-1:0] mask;
		mask = alive ? survive_r : birth_r;
		return mask[n];
	endfunction

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic predict_cell(input func_t f, input int r, input int c, input logic wv);
		int nr;
		int nc;
		int a;
		bit in_area;
		cell_result_t res;
		nr = clamp_size(rows_r, MAX_ROWS);
		nc = clamp_size(cols_r, MAX_COLS);
		in_area = (r < nr) && (c < nc);
		a = r * MAX_COLS + c;
		res = '0;
		case (f)
			FUNC_WRITE: begin
				if (in_area)
					grid_q[a] = wv;
			end
			FUNC_READ: begin
				if (in_area)
					res.alive = grid_q[a];
			end
			FUNC_GEN: begin
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						scratch_q[i * MAX_COLS + j] = rule_out(grid_q[i * MAX_COLS + j],
							live_around(i, j, nr, nc));
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						grid_q[i * MAX_COLS + j] = scratch_q[i * MAX_COLS + j];
			end
			default: begin
				if (in_area) begin
					res.live_nbrs = CNT_W'(live_around(r, c, nr, nc));
					res.alive = rule_out(grid_q[a], res.live_nbrs);
					grid_q[a] = res.alive;
				end
			end
		endcase
		result_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			birth_r = BIRTH_RESET;
			survive_r = SURVIVE_RESET;
			rows_r = ROWS_RESET;
			cols_r = COLS_RESET;
			result_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_BIRTH:   birth_r = pwdata[MASK_W-1:0];
					REG_SURVIVE: survive_r = pwdata[MASK_W-1:0];
					REG_ROWS:    rows_r = pwdata[SIZE_W-1:0];
					REG_COLS:    cols_r = pwdata[SIZE_W-1:0];
				endcase
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", neighbor_count, '0);
				end else begin
					want = result_q.pop_front();
					checked_count++;
					if (cell_value !== want.alive)
						report_mismatch("cell_value", CNT_W'(cell_value), CNT_W'(want.alive));
					if (neighbor_count !== want.live_nbrs)
						report_mismatch("neighbor_count", neighbor_count, want.live_nbrs);
				end
			end
			if (in_valid && in_ready)
				predict_cell(func_t'(func), cell_row, cell_col, write_value);
			pending = result_q.size();
		end
	end

endmodule

### sim/life_like_automaton_engine_tb.sv
// Top of the life-like automaton engine testbench: clock, reset, register setup,
// directed and random items with bursty input and a stalling receiver, and the verdict.
// Depends on lla_pkg, the engine RTL and life_like_automaton_engine_checker.
`timescale 1ns / 1ps

module life_like_automaton_engine_tb import lla_pkg::*; ();

	localparam int ITEM_TARGET = 1950;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = FUNC_WRITE;
	logic [ROW_W-1:0]   cell_row = '0;
	logic [COL_W-1:0]   cell_col = '0;
	logic               write_value = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               cell_value;
	logic [CNT_W-1:0]   neighbor_count;

	int fail_count;
	int pending;
	int checked_count;

	bit cell_known [0:DEPTH-1];
	int rows_eff = MAX_ROWS;
	int cols_eff = MAX_COLS;
	int burst_left = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;
	int n_items = 0;
	int n_gens = 0;
	int n_updates = 0;
	int n_settings = 0;

	life_like_automaton_engine dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.cell_row(cell_row), .cell_col(cell_col), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_value(cell_value), .neighbor_count(neighbor_count)
	);

	life_like_automaton_engine_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.cell_row(cell_row), .cell_col(cell_col), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_value(cell_value), .neighbor_count(neighbor_count),
		.fail_count(fail_count), .pending(pending), .checked_count(checked_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: random ready patterns, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int max_v);
		if (v == 0)
			return 1;
		if (v > max_v)
			return max_v;
		return v;
	endfunction

	function automatic bit nbhd_known(input int r, input int c);
		for (int i = r - 1; i <= r + 1; i++)
			for (int j = c - 1; j <= c + 1; j++)
				if (i >= 0 && i < rows_eff && j >= 0 && j < cols_eff && !cell_known[i * MAX_COLS + j])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit area_known();
		for (int i = 0; i < rows_eff; i++)
			for (int j = 0; j < cols_eff; j++)
				if (!cell_known[i * MAX_COLS + j])
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic send_item(input func_t f, input int r, input int c, input logic wv);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		cell_row <= ROW_W'(r);
		cell_col <= COL_W'(c);
		write_value <= wv;
		do
			@(posedge clk);
		while (!in_ready);
		n_items++;
	endtask

	// Turns an item that would touch never-written cells into a write of the addressed cell.
	task automatic issue(input func_t f, input int r, input int c, input logic wv);
		bit in_area;
		in_area = (r < rows_eff) && (c < cols_eff);
		if (f == FUNC_READ && in_area && !cell_known[r * MAX_COLS + c])
			f = FUNC_WRITE;
		if (f == FUNC_UPDATE && in_area && !nbhd_known(r, c))
			f = FUNC_WRITE;
		if (f == FUNC_GEN && !area_known())
			f = FUNC_WRITE;
		if (f == FUNC_WRITE && in_area)
			cell_known[r * MAX_COLS + c] = 1'b1;
		if (f == FUNC_GEN)
			n_gens++;
		if (f == FUNC_UPDATE && in_area)
			n_updates++;
		send_item(f, r, c, wv);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_grid(input logic [MASK_W-1:0] birth, input logic [MASK_W-1:0] survive,
		input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
		logic [PDATA_W-1:0] noise;
		noise = $urandom();
		cfg_write(REG_BIRTH, {noise[PDATA_W-1:MASK_W], birth});
		noise = $urandom();
		cfg_write(REG_SURVIVE, {noise[PDATA_W-1:MASK_W], survive});
		noise = $urandom();
		cfg_write(REG_ROWS, {noise[PDATA_W-1:SIZE_W], rows});
		noise = $urandom();
		cfg_write(REG_COLS, {noise[PDATA_W-1:SIZE_W], cols});
		rows_eff = clamp_size(rows, MAX_ROWS);
		cols_eff = clamp_size(cols, MAX_COLS);
		n_settings++;
	endtask

	task automatic fill_area();
		for (int i = 0; i < rows_eff; i++)
			for (int j = 0; j < cols_eff; j++)
				if (!cell_known[i * MAX_COLS + j])
					issue(FUNC_WRITE, i, j, 1'($urandom_range(0, 1)));
	endtask

	task automatic random_item();
		func_t f;
		int r;
		int c;
		int pick;
		int gen_pct;
		pick = $urandom_range(0, 99);
		gen_pct = (rows_eff * cols_eff <= 64) ? 6 : 2;
		if (pick < gen_pct)
			f = FUNC_GEN;
		else if (pick < 40)
			f = FUNC_WRITE;
		else if (pick < 70)
			f = FUNC_READ;
		else
			f = FUNC_UPDATE;
		if ($urandom_range(0, 6) == 0) begin
			r = $urandom_range(0, MAX_ROWS - 1);
			c = $urandom_range(0, MAX_COLS - 1);
		end else begin
			r = $urandom_range(0, rows_eff - 1);
			c = $urandom_range(0, cols_eff - 1);
		end
		issue(f, r, c, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Full-size grid with the reset rules: corners and their neighborhoods.
		issue(FUNC_WRITE, 0, 0, 1'b1);
		issue(FUNC_WRITE, 0, 1, 1'b1);
		issue(FUNC_WRITE, 1, 0, 1'b1);
		issue(FUNC_WRITE, 1, 1, 1'b0);
		issue(FUNC_READ, 0, 0, 1'b0);
		issue(FUNC_READ, 1, 1, 1'b1);
		issue(FUNC_UPDATE, 0, 0, 1'b0);
		issue(FUNC_WRITE, 63, 63, 1'b1);
		issue(FUNC_WRITE, 62, 62, 1'b0);
		issue(FUNC_WRITE, 62, 63, 1'b1);
		issue(FUNC_WRITE, 63, 62, 1'b1);
		issue(FUNC_UPDATE, 63, 63, 1'b1);
		issue(FUNC_READ, 63, 63, 1'b0);
		drain();

		// Three by three, all alive: the center sees eight neighbors.
		set_grid(9'h1FF, 9'h000, 7'd3, 7'd3);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				issue(FUNC_WRITE, i, j, 1'b1);
		issue(FUNC_UPDATE, 1, 1, 1'b0);
		issue(FUNC_UPDATE, 0, 0, 1'b1);
		issue(FUNC_READ, 5, 5, 1'b0);
		issue(FUNC_WRITE, 5, 5, 1'b1);
		issue(FUNC_UPDATE, 7, 2, 1'b0);
		issue(FUNC_GEN, 0, 0, 1'b0);
		issue(FUNC_READ, 1, 1, 1'b0);
		issue(FUNC_READ, 2, 2, 1'b1);

		while (n_items < ITEM_TARGET) begin
			drain();
			case ($urandom_range(0, 4))
				0: begin
					birth = $urandom_range(0, 1) ? 9'h000 : 9'h1FF;
					survive = $urandom_range(0, 1) ? 9'h000 : 9'h1FF;
				end
				1: begin
					birth = BIRTH_RESET;
					survive = SURVIVE_RESET;
				end
				default: begin
					birth = MASK_W'($urandom_range(0, 511));
					survive = MASK_W'($urandom_range(0, 511));
				end
			endcase
			case ($urandom_range(0, 9))
				0: begin
					rows = SIZE_W'($urandom_range(0, 1));
					cols = SIZE_W'($urandom_range(64, 127));
				end
				1: begin
					rows = SIZE_W'($urandom_range(64, 127));
					cols = SIZE_W'($urandom_range(0, 2));
				end
				2, 3: begin
					rows = SIZE_W'($urandom_range(1, 12));
					cols = SIZE_W'($urandom_range(1, 12));
				end
				default: begin
					rows = SIZE_W'($urandom_range(1, 8));
					cols = SIZE_W'($urandom_range(1, 8));
				end
			endcase
			set_grid(birth, survive, rows, cols);
			fill_area();
			no_gaps = ($urandom_range(0, 4) == 0);
			if (n_settings == 5)
				hold_req = 1'b1;
			repeat ($urandom_range(30, 110))
				random_item();
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d items over %0d register settings: %0d generations, %0d in-place updates.",
			n_items, n_settings, n_gens, n_updates);
		$display("Compared %0d results, %0d mismatches.", checked_count, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
